// File: rtl/pcir_pkg.sv
// pcir_pkg: shared constants for the prime count in range unit
// no dependencies; imported by prime_count_in_range_unit and its bench
package pcir_pkg;

  // width of the prime count result
  localparam int unsigned COUNT_WIDTH = 13;

  // trial divisors start at the first odd prime
  localparam int unsigned FIRST_DIVISOR = 3;

  // smallest prime, the only even one
  localparam int unsigned SMALLEST_PRIME = 2;

endpackage

// File: rtl/prime_count_in_range_unit.sv
// prime_count_in_range_unit: counts primes in an inclusive range by trial division
// depends on pcir_pkg (count width and divisor constants)
//
//   channel   | ports                                  | direction | handshake
//   ----------+----------------------------------------+-----------+--------------------
//   range in  | range_start_i, range_end_i             | in        | start_i && !busy_o
//   count out | prime_count_o                          | out       | done_o, one cycle
//
// each number of the range passes through the test and advance states and, per odd
//   trial divisor tried, a square check, the bit-serial remainder unit at one bit a
//   cycle, then a divisor step
// an empty range (start above end) returns 0 in the cycle right after the transfer
// reset clears the sequencer and the count; busy_o is low after reset
// busy_o stays high from the accepted transfer until the cycle after done_o
// the receiver cannot stall: done_o marks the result for exactly one cycle
module prime_count_in_range_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [VALUE_WIDTH-1:0]            range_start_i,
  input  logic [VALUE_WIDTH-1:0]            range_end_i,
  output logic                              done_o,
  output logic [pcir_pkg::COUNT_WIDTH-1:0]  prime_count_o
);
  import pcir_pkg::*;

  localparam int unsigned IdxWidth = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned SqWidth  = VALUE_WIDTH + 2;
  localparam int unsigned RemWidth = VALUE_WIDTH + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StTest  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StStep  = 3'd4;
  localparam logic [2:0] StAdv   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] FirstDiv = VALUE_WIDTH'(FIRST_DIVISOR);
  localparam logic [SqWidth-1:0]     FirstSq  = SqWidth'(FIRST_DIVISOR * FIRST_DIVISOR);
  localparam logic [VALUE_WIDTH-1:0] TwoVal   = VALUE_WIDTH'(SMALLEST_PRIME);

  logic [2:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] hi_q, hi_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic [SqWidth-1:0]     sq_q, sq_d;
  logic [RemWidth-1:0]    rem_q, rem_d;
  logic [IdxWidth-1:0]    idx_q, idx_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  logic [RemWidth-1:0]    rem_shift;
  logic [RemWidth-1:0]    rem_sub;
  logic                   rem_ge;
  logic [COUNT_WIDTH-1:0] count_inc;

  // bit-serial remainder: shift in the next bit of n, subtract d when it fits
  assign rem_shift = {rem_q[RemWidth-2:0], n_q[idx_q]};
  assign rem_ge    = rem_shift >= {1'b0, d_q};
  assign rem_sub   = rem_ge ? (rem_shift - {1'b0, d_q}) : rem_shift;

  // count saturates at its all-ones value
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    hi_d    = hi_q;
    d_d     = d_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    count_d = count_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          n_d     = range_start_i;
          hi_d    = range_end_i;
          count_d = '0;
          state_d = (range_start_i > range_end_i) ? StDone : StTest;
        end
      end
      StTest: begin
        if (n_q == TwoVal) begin
          count_d = count_inc;
          state_d = StAdv;
        end else if (n_q < TwoVal || !n_q[0]) begin
          state_d = StAdv;
        end else begin
          d_d     = FirstDiv;
          sq_d    = FirstSq;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sq_q > SqWidth'(n_q)) begin
          // no divisor up to the square root
          count_d = count_inc;
          state_d = StAdv;
        end else begin
          rem_d   = '0;
          idx_d   = IdxWidth'(VALUE_WIDTH - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d = rem_sub;
        idx_d = idx_q - 1'b1;
        if (idx_q == '0) begin
          state_d = (rem_sub == '0) ? StAdv : StStep;
        end
      end
      StStep: begin
        // (d + 2)^2 = d^2 + 4d + 4
        sq_d    = sq_q + {d_q, 2'b00} + SqWidth'(4);
        d_d     = d_q + TwoVal;
        state_d = StCheck;
      end
      StAdv: begin
        if (n_q == hi_q) begin
          state_d = StDone;
        end else begin
          n_d     = n_q + 1'b1;
          state_d = StTest;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    hi_q  <= hi_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    idx_q <= idx_d;
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = (state_q == StDone);
  assign prime_count_o = count_q;

  // result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // an empty range reports zero right after the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && range_start_i > range_end_i) |=> (done_o && prime_count_o == '0))
    else $error("empty range did not return zero");

  // trial divisors are always odd and at least three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (d_q[0] && d_q >= FirstDiv))
    else $error("bad trial divisor");

  // a remainder step never leaves a value at or above the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |=> (rem_q < {1'b0, d_q}))
    else $error("remainder out of range");

endmodule

// File: bench/prime_count_in_range_unit_tb.sv
// prime_count_in_range_unit_tb: self-checking bench for the trial division prime counter
// depends on pcir_pkg and prime_count_in_range_unit; predicts each count in the bench
`timescale 1ns / 100ps

module prime_count_in_range_unit_tb;
  import pcir_pkg::*;

  localparam int unsigned VALUE_WIDTH    = 16;
  localparam int unsigned VALUE_MAX      = (1 << VALUE_WIDTH) - 1;
  localparam int unsigned COUNT_MAX      = (1 << COUNT_WIDTH) - 1;
  localparam int unsigned RANDOM_RANGES  = 100;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam longint      TIMEOUT_NS     = 200_000_000;

  typedef struct {
    logic [VALUE_WIDTH-1:0] lo_value;
    logic [VALUE_WIDTH-1:0] hi_value;
    logic [COUNT_WIDTH-1:0] count;
  } range_count_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [VALUE_WIDTH-1:0] range_start_i;
  logic [VALUE_WIDTH-1:0] range_end_i;
  logic                   done_o;
  logic [COUNT_WIDTH-1:0] prime_count_o;

  range_count_t pending_counts[$];
  range_count_t checked_range;
  int unsigned  failures;
  int unsigned  ranges_sent;
  int unsigned  empty_ranges_sent;
  int unsigned  prime_ranges_sent;
  int unsigned  counts_checked;
  bit           gaps_enabled;

  prime_count_in_range_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .range_start_i(range_start_i),
    .range_end_i  (range_end_i),
    .done_o       (done_o),
    .prime_count_o(prime_count_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic bit value_is_prime(int unsigned n);
    int unsigned divisor;
    if (n < SMALLEST_PRIME) return 1'b0;
    if (n == SMALLEST_PRIME) return 1'b1;
    if ((n % 2) == 0) return 1'b0;
    for (divisor = FIRST_DIVISOR; divisor * divisor <= n; divisor += 2) begin
      if ((n % divisor) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] primes_in_range(
    logic [VALUE_WIDTH-1:0] lo_value,
    logic [VALUE_WIDTH-1:0] hi_value
  );
    int unsigned n;
    int unsigned total;
    total = 0;
    if (lo_value <= hi_value) begin
      for (n = 32'(lo_value); n <= 32'(hi_value); n++) begin
        if (value_is_prime(n) && total < COUNT_MAX) total++;
      end
    end
    return total[COUNT_WIDTH-1:0];
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // one range transfer: optional idle gap, then start held until busy is low
  task automatic send_range(logic [VALUE_WIDTH-1:0] lo_value, logic [VALUE_WIDTH-1:0] hi_value);
    int unsigned  gap;
    range_count_t item;
    gap = gaps_enabled ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    range_start_i <= lo_value;
    range_end_i   <= hi_value;
    do @(posedge clk_i); while (busy_o);
    item.lo_value = lo_value;
    item.hi_value = hi_value;
    item.count    = primes_in_range(lo_value, hi_value);
    pending_counts.push_back(item);
    ranges_sent++;
    if (lo_value > hi_value) empty_ranges_sent++;
    if (item.count != 0) prime_ranges_sent++;
  endtask

  // every range yields a count, so an empty queue means the unit is idle
  task automatic wait_for_counts();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_smallest_values();
    send_range(0, 0);
    send_range(1, 1);
    send_range(2, 2);
    send_range(3, 3);
    send_range(4, 4);
    send_range(0, 1);
    send_range(0, 2);
    send_range(9, 9);
    send_range(25, 25);
    send_range(0, 100);
    send_range(0, 1000);
    wait_for_counts();
  endtask

  task automatic test_empty_ranges();
    send_range(1, 0);
    send_range(VALUE_WIDTH'(VALUE_MAX), 0);
    send_range(VALUE_WIDTH'(VALUE_MAX), VALUE_WIDTH'(VALUE_MAX - 1));
    send_range(16'h8000, 16'h7fff);
    send_range(16'h5555, 16'h2aaa);
    wait_for_counts();
  endtask

  task automatic test_top_of_range();
    send_range(VALUE_WIDTH'(VALUE_MAX), VALUE_WIDTH'(VALUE_MAX));
    send_range(65521, 65521);
    send_range(65521, VALUE_WIDTH'(VALUE_MAX));
    send_range(VALUE_WIDTH'(VALUE_MAX - 1), VALUE_WIDTH'(VALUE_MAX));
    send_range(16'haaaa, 16'haaaa + 16'd10);
    send_range(16'h5555, 16'h5555 + 16'd10);
    wait_for_counts();
  endtask

  task automatic test_random_ranges();
    int unsigned            idx;
    int unsigned            kind;
    int unsigned            upper;
    logic [VALUE_WIDTH-1:0] lo_value;
    logic [VALUE_WIDTH-1:0] hi_value;
    for (idx = 0; idx < RANDOM_RANGES; idx++) begin
      // a stretch back to back, no idle cycles
      gaps_enabled = !(idx >= 40 && idx < 60);
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        // short window anywhere, most cost lands on the few primes near the top
        lo_value = VALUE_WIDTH'($urandom);
        upper    = 32'(lo_value) + $urandom_range(0, 12);
        hi_value = VALUE_WIDTH'((upper > VALUE_MAX) ? VALUE_MAX : upper);
      end else if (kind == 5) begin
        lo_value = VALUE_WIDTH'($urandom_range(1, VALUE_MAX));
        hi_value = VALUE_WIDTH'($urandom_range(0, 32'(lo_value) - 1));
      end else if (kind <= 7) begin
        lo_value = VALUE_WIDTH'($urandom_range(0, 400));
        hi_value = VALUE_WIDTH'(32'(lo_value) + $urandom_range(0, 80));
      end else if (kind == 8) begin
        lo_value = VALUE_WIDTH'($urandom);
        hi_value = lo_value;
      end else begin
        lo_value = VALUE_WIDTH'($urandom_range(0, 3000));
        hi_value = VALUE_WIDTH'(32'(lo_value) + $urandom_range(0, 200));
      end
      send_range(lo_value, hi_value);
      if ($urandom_range(0, 11) == 0) wait_for_counts();
    end
    gaps_enabled = 1'b1;
    wait_for_counts();
  endtask

  // count check, sampled at the edge that ends the done cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_counts.size() == 0) begin
        note_failure($sformatf("count %0d with no range pending", prime_count_o));
      end else begin
        checked_range = pending_counts.pop_front();
        counts_checked++;
        if (prime_count_o !== checked_range.count) begin
          note_failure($sformatf("range [%0d, %0d]: expected count %0d, got %0d",
                                 checked_range.lo_value, checked_range.hi_value,
                                 checked_range.count, prime_count_o));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d counts outstanding", pending_counts.size());
    $display("prime_count_in_range_unit_tb failed");
    $finish;
  end

  initial begin
    failures          = 0;
    ranges_sent       = 0;
    empty_ranges_sent = 0;
    prime_ranges_sent = 0;
    counts_checked    = 0;
    gaps_enabled      = 1'b1;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    range_start_i     = '0;
    range_end_i       = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_smallest_values();
    test_empty_ranges();
    test_top_of_range();
    test_random_ranges();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_counts.size() != 0) begin
      note_failure($sformatf("%0d counts never arrived", pending_counts.size()));
    end

    $display("covered %0d ranges (%0d empty, %0d holding primes), %0d counts compared",
             ranges_sent, empty_ranges_sent, prime_ranges_sent, counts_checked);
    $display("%0d failures", failures);
    if (failures == 0) begin
      $display("prime_count_in_range_unit_tb passed");
    end else begin
      $display("prime_count_in_range_unit_tb failed");
    end
    $finish;
  end

endmodule
